@@ hw/rtl/bpd_pkg.sv @@
// shared types, constants and codes of the pulse beat detector
package bpd_pkg;

    localparam int LEVEL_W    = 10;
    localparam int MS_W       = 16;
    localparam int BPM_W      = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFTH_W    = MS_W - 2;

    localparam int HISTORY_DEPTH_DEF = 10;

    localparam logic [LEVEL_W-1:0] DEFAULT_THRESHOLD_RST = 10'd530;
    localparam logic [LEVEL_W-1:0] LEVEL_SEED_RST        = 10'd512;
    localparam logic [MS_W-1:0]    MIN_GAP_RST           = 16'd250;
    localparam logic [MS_W-1:0]    TIMEOUT_RST           = 16'd2500;
    localparam logic [MS_W-1:0]    INTERVAL_RST          = 16'd600;
    localparam logic [MS_W-1:0]    MINUTE_MS             = 16'd60000;
    localparam logic [MS_W-1:0]    SINCE_MAX             = '1;
    localparam logic [BPM_W-1:0]   BPM_MAX               = '1;

    // x / 5 == (x * 52429) >> 18 for every 16-bit x
    localparam logic [MS_W-1:0] RECIP_FIFTH       = 16'd52429;
    localparam int              RECIP_FIFTH_SHIFT = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_THRESHOLD = 2'd0,
        REG_LEVEL_SEED        = 2'd1,
        REG_MIN_GAP           = 2'd2,
        REG_TIMEOUT           = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT,
        S_AVG,
        S_RATE_START,
        S_RATE_WAIT,
        S_FINISH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
        logic avg_load;
        logic div_start;
        logic finish;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic beat_rate;
        logic div_busy;
        logic div_done;
    } dp_status_t;

endpackage

@@ hw/rtl/bpd_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module bpd_div #(
    parameter int DIV_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] trial;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = !trial[DIV_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/bpd_dpath.sv @@
// datapath: detector state, interval history, rate divider and result register
module bpd_dpath #(
    parameter int HISTORY_DEPTH = bpd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bpd_pkg::dp_cmd_t                     cmd,
    output bpd_pkg::dp_status_t                  sts,
    input  logic                                 cfg_write,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [bpd_pkg::LEVEL_W-1:0]          sample_level,
    input  logic [bpd_pkg::MS_W-1:0]             elapsed_ms,
    output logic                                 pulse_active,
    output logic                                 rate_new,
    output logic [bpd_pkg::BPM_W-1:0]            beats_per_minute,
    output logic [bpd_pkg::MS_W-1:0]             interval_ms,
    output logic [bpd_pkg::LEVEL_W-1:0]          current_threshold
);

    localparam int LW    = bpd_pkg::LEVEL_W;
    localparam int MW    = bpd_pkg::MS_W;
    localparam int BW    = bpd_pkg::BPM_W;
    localparam int FW    = bpd_pkg::FIFTH_W;
    localparam int SUM_W = MW + $clog2(HISTORY_DEPTH);
    localparam int DIV_W = MW;

    // sum / HISTORY_DEPTH as (sum * ceil(2^AVG_SHIFT / depth)) >> AVG_SHIFT, exact for SUM_W bits
    localparam int         RECIP_W        = SUM_W + 1;
    localparam int         PROD_W         = SUM_W + RECIP_W;
    localparam int         AVG_SHIFT      = SUM_W + $clog2(HISTORY_DEPTH);
    localparam logic [63:0] AVG_RECIP_FULL =
        ((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH);
    localparam logic [RECIP_W-1:0] AVG_RECIP = AVG_RECIP_FULL[RECIP_W-1:0];

    // configuration
    logic [LW-1:0] dflt_thr_reg;
    logic [LW-1:0] seed_reg;
    logic [MW-1:0] min_gap_reg;
    logic [MW-1:0] timeout_reg;

    // captured transaction and staged values
    logic [LW-1:0] sample_reg;
    logic [MW-1:0] elapsed_reg;
    logic [MW-1:0] since_sat_reg;
    logic [FW-1:0] fifth_reg;

    // detector state
    logic [MW-1:0] since_reg,    since_next;
    logic [MW-1:0] last_int_reg, last_int_next;
    logic [LW-1:0] peak_reg,     peak_next;
    logic [LW-1:0] trough_reg,   trough_next;
    logic [LW-1:0] thr_reg,      thr_next;
    logic [BW-1:0] rate_reg,     rate_next;
    logic          in_pulse_reg, in_pulse_next;
    logic          first_reg,    first_next;
    logic          second_reg,   second_next;
    logic          beat_rate_reg;
    logic          timeout_hit_reg;

    logic [MW-1:0]    hist_reg [HISTORY_DEPTH];
    logic [SUM_W-1:0] sum_reg;
    logic [MW-1:0]    avg_reg;

    // result register
    logic          out_pulse_reg;
    logic          out_new_reg;
    logic [BW-1:0] out_bpm_reg;
    logic [MW-1:0] out_int_reg;
    logic [LW-1:0] out_thr_reg;

    logic [MW:0]      since_sum;
    logic [MW-1:0]    since_sat;
    logic [2*MW-1:0]  fifth_prod;
    logic [MW-1:0]    refractory;
    logic             past_refr;
    logic             below;
    logic             above;
    logic [LW-1:0]    peak_trk;
    logic [LW-1:0]    trough_trk;
    logic             beat;
    logic             beat_rate;
    logic             pulse_end;
    logic             timeout_hit;
    logic [LW:0]      amp;
    logic [LW:0]      amp_adj;
    logic [LW:0]      half;
    logic [LW-1:0]    mid;
    logic [SUM_W-1:0] sum_seed;
    logic [SUM_W-1:0] sum_shift;
    logic [PROD_W-1:0] avg_prod;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quotient;
    logic             div_busy;
    logic             div_done;
    logic [BW-1:0]    bpm_sat;

    // eval stage: saturating time since beat and a fifth of the last interval
    always_comb
    begin
        since_sum  = {1'b0, since_reg} + {1'b0, elapsed_reg};
        since_sat  = since_sum[MW] ? bpd_pkg::SINCE_MAX : since_sum[MW-1:0];
        fifth_prod = last_int_reg * bpd_pkg::RECIP_FIFTH;
    end

    // commit stage: tracking, beat decision, pulse end and timeout
    always_comb
    begin
        refractory = {1'b0, fifth_reg, 1'b0} + {2'b00, fifth_reg};
        past_refr  = since_sat_reg > refractory;
        below      = sample_reg < thr_reg;
        above      = sample_reg > thr_reg;
        trough_trk = (below && past_refr && (sample_reg < trough_reg)) ? sample_reg : trough_reg;
        peak_trk   = (above && (sample_reg > peak_reg)) ? sample_reg : peak_reg;
        beat       = (since_sat_reg > min_gap_reg) && above && !in_pulse_reg && past_refr;
        beat_rate  = beat && !first_reg;
        pulse_end  = below && in_pulse_reg;
        // the arming beat ends the step before the timeout check
        timeout_hit = (since_sat_reg > timeout_reg) && !(beat && first_reg);

        // midpoint, halving truncated toward zero
        amp     = {1'b0, peak_trk} - {1'b0, trough_trk};
        amp_adj = amp + (LW + 1)'(amp[LW]);
        half    = {amp_adj[LW], amp_adj[LW:1]};
        mid     = trough_trk + half[LW-1:0];

        sum_seed  = SUM_W'(since_sat_reg) * SUM_W'(HISTORY_DEPTH);
        sum_shift = sum_reg - SUM_W'(hist_reg[0]) + SUM_W'(since_sat_reg);
    end

    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);

    assign bpm_sat = (|div_quotient[DIV_W-1:BW]) ? bpd_pkg::BPM_MAX : div_quotient[BW-1:0];

    always_comb
    begin
        since_next    = since_reg;
        last_int_next = last_int_reg;
        peak_next     = peak_reg;
        trough_next   = trough_reg;
        thr_next      = thr_reg;
        rate_next     = rate_reg;
        in_pulse_next = in_pulse_reg;
        first_next    = first_reg;
        second_next   = second_reg;

        if (cmd.commit)
        begin
            since_next  = since_sat_reg;
            peak_next   = peak_trk;
            trough_next = trough_trk;
            if (beat)
            begin
                in_pulse_next = 1'b1;
                last_int_next = since_sat_reg;
                since_next    = '0;
                if (second_reg)
                begin
                    second_next = 1'b0;
                end
                if (first_reg)
                begin
                    first_next  = 1'b0;
                    second_next = 1'b1;
                end
            end
            if (pulse_end)
            begin
                in_pulse_next = 1'b0;
                thr_next      = mid;
                peak_next     = mid;
                trough_next   = mid;
            end
            if (timeout_hit)
            begin
                thr_next    = dflt_thr_reg;
                peak_next   = seed_reg;
                trough_next = seed_reg;
                since_next  = '0;
                first_next  = 1'b1;
                second_next = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            if (timeout_hit_reg)
            begin
                rate_next = '0;
            end
            else if (beat_rate_reg)
            begin
                rate_next = bpm_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_thr_reg    <= bpd_pkg::DEFAULT_THRESHOLD_RST;
            seed_reg        <= bpd_pkg::LEVEL_SEED_RST;
            min_gap_reg     <= bpd_pkg::MIN_GAP_RST;
            timeout_reg     <= bpd_pkg::TIMEOUT_RST;
            since_reg       <= '0;
            last_int_reg    <= bpd_pkg::INTERVAL_RST;
            peak_reg        <= bpd_pkg::LEVEL_SEED_RST;
            trough_reg      <= bpd_pkg::LEVEL_SEED_RST;
            thr_reg         <= bpd_pkg::DEFAULT_THRESHOLD_RST;
            rate_reg        <= '0;
            in_pulse_reg    <= 1'b0;
            first_reg       <= 1'b1;
            second_reg      <= 1'b0;
            beat_rate_reg   <= 1'b0;
            timeout_hit_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (bpd_pkg::cfg_reg_t'(cfg_index))
                    bpd_pkg::REG_DEFAULT_THRESHOLD: dflt_thr_reg <= cfg_data[LW-1:0];
                    bpd_pkg::REG_LEVEL_SEED:        seed_reg     <= cfg_data[LW-1:0];
                    bpd_pkg::REG_MIN_GAP:           min_gap_reg  <= cfg_data[MW-1:0];
                    bpd_pkg::REG_TIMEOUT:           timeout_reg  <= cfg_data[MW-1:0];
                endcase
            end
            since_reg    <= since_next;
            last_int_reg <= last_int_next;
            peak_reg     <= peak_next;
            trough_reg   <= trough_next;
            thr_reg      <= thr_next;
            rate_reg     <= rate_next;
            in_pulse_reg <= in_pulse_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            if (cmd.commit)
            begin
                beat_rate_reg   <= beat_rate;
                timeout_hit_reg <= timeout_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg  <= sample_level;
            elapsed_reg <= elapsed_ms;
        end
        if (cmd.eval)
        begin
            since_sat_reg <= since_sat;
            fifth_reg     <= fifth_prod[bpd_pkg::RECIP_FIFTH_SHIFT +: FW];
        end
        // second beat seeds every entry, later beats shift in the newest
        if (cmd.commit && beat_rate)
        begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            begin
                hist_reg[i] <= second_reg ? since_sat_reg : hist_reg[i+1];
            end
            hist_reg[HISTORY_DEPTH-1] <= since_sat_reg;
            sum_reg <= second_reg ? sum_seed : sum_shift;
        end
        if (cmd.avg_load)
        begin
            avg_reg <= avg_prod[AVG_SHIFT +: MW];
        end
        if (cmd.out_load)
        begin
            out_pulse_reg <= in_pulse_reg;
            out_new_reg   <= beat_rate_reg;
            out_bpm_reg   <= rate_reg;
            out_int_reg   <= last_int_reg;
            out_thr_reg   <= thr_reg;
        end
    end

    // average from the reciprocal multiply, then the minute divided by the average
    assign div_dividend = bpd_pkg::MINUTE_MS;
    assign div_divisor  = avg_reg;

    bpd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign sts.beat_rate = beat_rate;
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;

    assign pulse_active      = out_pulse_reg;
    assign rate_new          = out_new_reg;
    assign beats_per_minute  = out_bpm_reg;
    assign interval_ms       = out_int_reg;
    assign current_threshold = out_thr_reg;

endmodule

@@ hw/rtl/bpd_ctrl.sv @@
// controller: step sequencer and result handshake
module bpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output bpd_pkg::dp_cmd_t    cmd,
    input  bpd_pkg::dp_status_t sts
);

    bpd_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpd_pkg::S_IDLE:       if (in_valid) state_next = bpd_pkg::S_EVAL;
            bpd_pkg::S_EVAL:       state_next = bpd_pkg::S_COMMIT;
            bpd_pkg::S_COMMIT:     state_next = sts.beat_rate ? bpd_pkg::S_AVG
                                                              : bpd_pkg::S_FINISH;
            bpd_pkg::S_AVG:        state_next = bpd_pkg::S_RATE_START;
            bpd_pkg::S_RATE_START: state_next = bpd_pkg::S_RATE_WAIT;
            bpd_pkg::S_RATE_WAIT:  if (sts.div_done) state_next = bpd_pkg::S_FINISH;
            bpd_pkg::S_FINISH:     state_next = bpd_pkg::S_OUT;
            bpd_pkg::S_OUT:        if (out_free) state_next = bpd_pkg::S_IDLE;
            default:               state_next = bpd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = (state_reg != bpd_pkg::S_IDLE);
        cmd.capture   = (state_reg == bpd_pkg::S_IDLE) && in_valid;
        cmd.eval      = (state_reg == bpd_pkg::S_EVAL);
        cmd.commit    = (state_reg == bpd_pkg::S_COMMIT);
        cmd.avg_load  = (state_reg == bpd_pkg::S_AVG);
        cmd.div_start = (state_reg == bpd_pkg::S_RATE_START);
        cmd.finish    = (state_reg == bpd_pkg::S_FINISH);
        cmd.out_load  = (state_reg == bpd_pkg::S_OUT) && out_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpd_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_starts_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == bpd_pkg::S_EVAL)
        else $error("accepted transaction did not start evaluation");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpd_pkg::S_OUT && out_free |=> out_valid_reg
                                                  && state_reg == bpd_pkg::S_IDLE)
        else $error("result not presented when the output slot was free");

    a_div_launched: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpd_pkg::S_RATE_START |=> sts.div_busy)
        else $error("divider did not start");

    a_wait_on_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpd_pkg::S_RATE_WAIT |-> sts.div_busy)
        else $error("waiting on an idle divider");

endmodule

@@ hw/rtl/pulse_beat_detector_unit.sv @@
// top level of the pulse beat detector: sequencer, datapath and ports
// transactions are handled one at a time; the next is accepted only once the result has
//   been loaded, so a finished result that waits on a stalled output holds the input
// reset: thresholds, seeds and timing registers return to defaults, detector rearms
module pulse_beat_detector_unit #(
    parameter int HISTORY_DEPTH = bpd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // input channel: one sensor sample per transaction
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpd_pkg::LEVEL_W-1:0]       sample_level,
    input  logic [bpd_pkg::MS_W-1:0]          elapsed_ms,

    // output channel: one result per sample
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              pulse_active,
    output logic                              rate_new,
    output logic [bpd_pkg::BPM_W-1:0]         beats_per_minute,
    output logic [bpd_pkg::MS_W-1:0]          interval_ms,
    output logic [bpd_pkg::LEVEL_W-1:0]       current_threshold,

    // configuration write port; the user must write it only while idle, the block does not enforce it
    input  logic                              cfg_write,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // the interval history holds nothing until the second beat seeds it

    // command and status between sequencer and datapath
    bpd_pkg::dp_cmd_t    cmd;
    bpd_pkg::dp_status_t sts;

    // sequencer: accepts a transaction only in idle, walks eval, commit,
    // the average and the rate division when a beat updates the rate, finish,
    // then loads the result register once it is free; a waiting result
    // blocks the next sample from being taken
    bpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: saturating beat timer, refractory from a reciprocal
    // multiply, peak and trough tracking, running interval sum, the average
    // from a reciprocal multiply and the divider that forms the rate
    bpd_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample_level      (sample_level),
        .elapsed_ms        (elapsed_ms),
        .pulse_active      (pulse_active),
        .rate_new          (rate_new),
        .beats_per_minute  (beats_per_minute),
        .interval_ms       (interval_ms),
        .current_threshold (current_threshold)
    );

endmodule
